// ===== design/dcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcsm_pkg: shared definitions for the dual-channel sliding median
// Window geometry, sample width, queue sizing and the queue entry type.
// ----------------------------------------------------------------------------
package dcsm_pkg;

  // Window and sample geometry.
  localparam int WINDOW_SIZE = 5;
  localparam int SAMPLE_BITS = 12;

  // Index width into a window, and count width that can hold WINDOW_SIZE itself.
  localparam int POS_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);

  // Position of the median in the sorted window (upper median for even sizes).
  localparam int MED_IDX = WINDOW_SIZE / 2;

  // Request queue between the front and back parts.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  // One classified request: both samples, the slot they go to, and whether
  // the window is full once they are written.
  typedef struct packed {
    sample_t left;
    sample_t right;
    pos_t    pos;
    logic    full;
  } dcsm_entry_t;

endpackage

// ===== design/dual_channel_sliding_median_core.sv =====
// ----------------------------------------------------------------------------
// dual_channel_sliding_median_core: two-channel sliding-window median filter
// Keeps a circular window per channel and reports both window medians.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one left and one right sample per request
//   (in_valid / in_stall). Every request yields exactly one result on the
//   output channel (out_valid / out_stall): both held medians and
//   out_window_ready, which is 1 once the window has filled.
//   Before the window first fills the medians read zero.
//   Flow: once the back end is idle, a request is popped from the queue and
//   written into both windows, is ranked over all WINDOW_SIZE slots (one
//   candidate slot a cycle, both channels in parallel) and is loaded into the
//   output register once the output slot is free; the ranking is skipped
//   before the window fills. The back end works on one request at a time and
//   pops the next only after the previous result is handed to the output.
//   A four-entry request queue takes new requests while the back end works.
//   Reset clears the slot pointer, fill count, queue and held medians.
//   While the receiver stalls, the result holds steady; the queue fills and
//   then in_stall rises.
// ----------------------------------------------------------------------------
module dual_channel_sliding_median_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dcsm_pkg::sample_t in_left_sample,
  input  dcsm_pkg::sample_t in_right_sample,
  output logic              out_valid,
  input  logic              out_stall,
  output dcsm_pkg::sample_t out_left_median,
  output dcsm_pkg::sample_t out_right_median,
  output logic              out_window_ready
);
  import dcsm_pkg::*;

  logic        q_push, q_pop, q_full, q_empty;
  dcsm_entry_t q_data, q_head;

  // Intake and classification.
  dcsm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_data)
  );

  // Request queue.
  dcsm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Window storage, median ranking and output register.
  dcsm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_median  (out_left_median),
    .out_right_median (out_right_median),
    .out_window_ready (out_window_ready)
  );

  // The back end never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("request popped from empty queue");

  // A result from a window that is not yet full carries zero medians.
  a_zero_before_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_window_ready) |->
      (out_left_median == '0) && (out_right_median == '0))
    else $error("nonzero median before window filled");

  // A request pushed without a pop in the same cycle leaves the queue nonempty.
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> !q_empty)
    else $error("pushed request lost from queue");

endmodule

// ===== design/dcsm_front.sv =====
// ----------------------------------------------------------------------------
// dcsm_front: request intake and classification
// Accepts sample pairs, assigns each its window slot and tags whether the
// window is full after it, then pushes the tagged request into the queue.
// ----------------------------------------------------------------------------
module dcsm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dcsm_pkg::sample_t     in_left_sample,
  input  dcsm_pkg::sample_t     in_right_sample,
  input  logic                  q_full,
  output logic                  q_push,
  output dcsm_pkg::dcsm_entry_t q_data
);
  import dcsm_pkg::*;

  localparam pos_t LAST_POS = POS_W'(WINDOW_SIZE - 1);
  localparam cnt_t FULL_CNT = CNT_W'(WINDOW_SIZE);
  localparam cnt_t PRE_FULL = CNT_W'(WINDOW_SIZE - 1);

  pos_t pos_r, pos_nxt;
  cnt_t fill_r, fill_nxt;

  // Back-pressure comes straight from the queue.
  assign in_stall = q_full;
  assign q_push   = in_valid && !in_stall;

  // Tag the request with its slot and the window state after it.
  assign q_data.left  = in_left_sample;
  assign q_data.right = in_right_sample;
  assign q_data.pos   = pos_r;
  assign q_data.full  = (fill_r == PRE_FULL) || (fill_r == FULL_CNT);

  // Slot pointer wraps at the window size; fill count saturates there.
  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    if (q_push) begin
      pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + POS_W'(1);
      if (fill_r != FULL_CNT) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== design/dcsm_fifo.sv =====
// ----------------------------------------------------------------------------
// dcsm_fifo: request queue between front and back
// A small register queue that lets the front keep taking requests while the
// back is busy computing medians or waiting on its receiver.
// ----------------------------------------------------------------------------
module dcsm_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dcsm_pkg::dcsm_entry_t push_data,
  input  logic                  pop,
  output logic                  full,
  output logic                  empty,
  output dcsm_pkg::dcsm_entry_t head
);
  import dcsm_pkg::*;

  dcsm_entry_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/dcsm_back.sv =====
// ----------------------------------------------------------------------------
// dcsm_back: window storage and median sequencer
// Pops requests, writes both windows, ranks one candidate slot per cycle
// against the window, once full, and presents the held medians on the output.
// ----------------------------------------------------------------------------
module dcsm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  dcsm_pkg::dcsm_entry_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dcsm_pkg::sample_t     out_left_median,
  output dcsm_pkg::sample_t     out_right_median,
  output logic                  out_window_ready
);
  import dcsm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam pos_t LAST_POS = POS_W'(WINDOW_SIZE - 1);
  localparam cnt_t MED_CNT  = CNT_W'(MED_IDX);

  logic [1:0] state_r, state_nxt;
  pos_t       cand_r, cand_nxt;
  logic       full_r, full_nxt;
  sample_t    hold_l_r, hold_l_nxt;
  sample_t    hold_r_r, hold_r_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_ready_r;
  sample_t    out_l_r, out_r_r;

  sample_t    lwin_r [WINDOW_SIZE];
  sample_t    rwin_r [WINDOW_SIZE];

  sample_t    cand_l, cand_r_val;
  cnt_t       lt_l, le_l, lt_r, le_r;
  logic       hit_l, hit_r;
  logic       slot_free;

  assign out_valid        = out_valid_r;
  assign out_left_median  = out_l_r;
  assign out_right_median = out_r_r;
  assign out_window_ready = out_ready_r;

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  // Rank the candidate slot: it holds the median when fewer than MED_IDX+1
  // entries lie below it and more than MED_IDX lie at or below it.
  always_comb begin
    cand_l     = lwin_r[cand_r];
    cand_r_val = rwin_r[cand_r];
    lt_l = '0;
    le_l = '0;
    lt_r = '0;
    le_r = '0;
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      if (lwin_r[j] < cand_l)      lt_l = lt_l + CNT_W'(1);
      if (lwin_r[j] <= cand_l)     le_l = le_l + CNT_W'(1);
      if (rwin_r[j] < cand_r_val)  lt_r = lt_r + CNT_W'(1);
      if (rwin_r[j] <= cand_r_val) le_r = le_r + CNT_W'(1);
    end
    hit_l = (lt_l <= MED_CNT) && (le_l > MED_CNT);
    hit_r = (lt_r <= MED_CNT) && (le_r > MED_CNT);
  end

  // Sequencer: pop, optional scan over all slots, then hand off the result.
  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    full_nxt      = full_r;
    hold_l_nxt    = hold_l_r;
    hold_r_nxt    = hold_r_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          full_nxt  = q_head.full;
          cand_nxt  = '0;
          state_nxt = q_head.full ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (hit_l) hold_l_nxt = cand_l;
        if (hit_r) hold_r_nxt = cand_r_val;
        if (cand_r == LAST_POS) begin
          state_nxt = ST_EMIT;
        end else begin
          cand_nxt = cand_r + POS_W'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cand_r      <= '0;
      full_r      <= 1'b0;
      hold_l_r    <= '0;
      hold_r_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cand_r      <= cand_nxt;
      full_r      <= full_nxt;
      hold_l_r    <= hold_l_nxt;
      hold_r_r    <= hold_r_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload loads when a result is handed off.
  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && slot_free) begin
      out_l_r     <= hold_l_r;
      out_r_r     <= hold_r_r;
      out_ready_r <= full_r;
    end
  end

  // Window storage: each popped request writes its slot in both windows.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      lwin_r[q_head.pos] <= q_head.left;
      rwin_r[q_head.pos] <= q_head.right;
    end
  end

endmodule
